>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and helpers shared by the stable priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Input word: one add or call request.
    typedef struct packed {
        logic       opcode;
        logic [2:0] priority_level;
        logic [15:0] patient_tag;
    } spq_in_t;

    // Result word: one per request.
    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] popped_tag;
        logic [2:0]  popped_level;
        logic [1:0]  room_code;
        logic [4:0]  entry_count;
    } spq_out_t;

    // One stored entry.
    typedef struct packed {
        logic [2:0]  level;
        logic [15:0] tag;
    } spq_entry_t;

    // Status from the sequencer to the top level.
    typedef struct packed {
        logic     idle;
        logic     done;
        spq_out_t word;
    } spq_resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_READ,
        ST_ADD_CMP,
        ST_POP_READ,
        ST_POP_DATA,
        ST_EMIT
    } spq_state_t;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_CALL = 1'b1;

    localparam logic [1:0] OUTC_ADDED  = 2'd0;
    localparam logic [1:0] OUTC_FULL   = 2'd1;
    localparam logic [1:0] OUTC_POPPED = 2'd2;
    localparam logic [1:0] OUTC_EMPTY  = 2'd3;

    localparam logic [2:0] LEVEL_CRITICAL = 3'd1;
    localparam logic [2:0] LEVEL_SERIOUS  = 3'd2;
    localparam logic [2:0] LEVEL_FAIR     = 3'd3;
    localparam logic [2:0] LEVEL_GOOD     = 3'd4;

    localparam logic [1:0] ROOM_EMERGENCY    = 2'd0;
    localparam logic [1:0] ROOM_EXAMINATION  = 2'd1;
    localparam logic [1:0] ROOM_CONSULTATION = 2'd2;
    localparam logic [1:0] ROOM_NONE         = 2'd3;

    function automatic logic [1:0] room_for(input logic [2:0] level);
        logic [1:0] room;
        if (level == LEVEL_CRITICAL) begin
            room = ROOM_EMERGENCY;
        end else if (level == LEVEL_SERIOUS) begin
            room = ROOM_EXAMINATION;
        end else if (level == LEVEL_FAIR || level == LEVEL_GOOD) begin
            room = ROOM_CONSULTATION;
        end else begin
            room = ROOM_NONE;
        end
        return room;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue sorted by level, first in first out among equals.
// ----------------------------------------------------------------------------
// Every input word yields one result word. A call reads the head entry from
// the RAM and advances the head; an add walks back from the tail through the
// single RAM, which moves one entry per cycle, and writes the new entry once
// it meets an entry of equal or lower level or reaches the head. A dropped add
// or a call on an empty queue skips the RAM and goes straight to its result.
// The input side is ready only while the sequencer is idle; a finished result
// sits in the output register, so the next word can be accepted before it is
// taken. Stored entries live in a RAM that needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire spq_pkg::spq_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output spq_pkg::spq_out_t      m_data
);
    import spq_pkg::*;

    logic      m_valid_reg, m_valid_next;
    spq_out_t  m_data_reg, m_data_next;
    logic      emit_ok;
    logic      start;
    spq_resp_t resp;

    spq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .req     (s_data),
        .emit_ok (emit_ok),
        .resp    (resp)
    );

    assign s_ready = resp.idle;
    assign start   = s_valid && resp.idle;
    // The output register can take a new word when empty or being drained.
    assign emit_ok = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (resp.done && emit_ok) begin
            m_valid_next = 1'b1;
            m_data_next  = resp.word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/spq_seq.sv
// ----------------------------------------------------------------------------
// spq_seq
// Sequencer that keeps the queue as a sorted ring in one RAM. An add walks
// back from the tail, moving each entry of higher level up one slot, one
// compare and one move per cycle. A call reads the head and advances it.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_seq #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire spq_pkg::spq_in_t   req,
    input  wire logic               emit_ok,
    output spq_pkg::spq_resp_t      resp
);
    import spq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    spq_state_t state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    spq_in_t       req_reg, req_next;
    spq_out_t      res_reg, res_next;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [PW-1:0] ram_raddr;
    spq_entry_t    ram_wdata;
    spq_entry_t    ram_rdata;
    spq_entry_t    new_entry;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - PW'(1);
    endfunction

    function automatic logic [4:0] count5(input logic [CW-1:0] c);
        logic [CW+4:0] ext;
        ext = {5'b0, c};
        return ext[4:0];
    endfunction

    spq_ram #(
        .WIDTH ($bits(spq_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign new_entry = '{level: req_reg.priority_level, tag: req_reg.patient_tag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        wr_ptr_reg <= wr_ptr_next;
        rd_ptr_reg <= rd_ptr_next;
        req_reg    <= req_next;
        res_reg    <= res_next;
    end

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        req_next    = req_reg;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_waddr   = wr_ptr_reg;
        ram_wdata   = new_entry;
        ram_raddr   = head_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    req_next = req;
                    if (req.opcode == OP_ADD) begin
                        if (count_reg == FULL_COUNT) begin
                            res_next = '{outcome: OUTC_FULL, popped_tag: '0,
                                         popped_level: '0, room_code: ROOM_NONE,
                                         entry_count: count5(count_reg)};
                            state_next = ST_EMIT;
                        end else begin
                            step_next   = count_reg;
                            wr_ptr_next = tail_reg;
                            state_next  = ST_ADD_READ;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_next = '{outcome: OUTC_EMPTY, popped_tag: '0,
                                         popped_level: '0, room_code: ROOM_NONE,
                                         entry_count: count5(count_reg)};
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_POP_READ;
                        end
                    end
                end
            end
            ST_ADD_READ: begin
                if (step_reg == '0) begin
                    // Reached the head: the new entry goes in the free slot.
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    tail_next  = ptr_inc(tail_reg);
                    res_next   = '{outcome: OUTC_ADDED, popped_tag: '0,
                                   popped_level: '0, room_code: ROOM_NONE,
                                   entry_count: count5(count_reg + CW'(1))};
                    state_next = ST_EMIT;
                end else begin
                    ram_raddr   = ptr_dec(wr_ptr_reg);
                    rd_ptr_next = ptr_dec(wr_ptr_reg);
                    state_next  = ST_ADD_CMP;
                end
            end
            ST_ADD_CMP: begin
                // Only a strictly higher level moves, which keeps equals in order.
                if (ram_rdata.level > req_reg.priority_level) begin
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata;
                    wr_ptr_next = rd_ptr_reg;
                    step_next   = step_reg - CW'(1);
                    if (step_reg == CW'(1)) begin
                        state_next = ST_ADD_READ;
                    end else begin
                        ram_raddr   = ptr_dec(rd_ptr_reg);
                        rd_ptr_next = ptr_dec(rd_ptr_reg);
                    end
                end else begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    tail_next  = ptr_inc(tail_reg);
                    res_next   = '{outcome: OUTC_ADDED, popped_tag: '0,
                                   popped_level: '0, room_code: ROOM_NONE,
                                   entry_count: count5(count_reg + CW'(1))};
                    state_next = ST_EMIT;
                end
            end
            ST_POP_READ: begin
                ram_raddr  = head_reg;
                state_next = ST_POP_DATA;
            end
            ST_POP_DATA: begin
                head_next  = ptr_inc(head_reg);
                count_next = count_reg - CW'(1);
                res_next   = '{outcome: OUTC_POPPED, popped_tag: ram_rdata.tag,
                               popped_level: ram_rdata.level,
                               room_code: room_for(ram_rdata.level),
                               entry_count: count5(count_reg - CW'(1))};
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign resp.idle = (state_reg == ST_IDLE);
    assign resp.done = (state_reg == ST_EMIT);
    assign resp.word = res_reg;

endmodule

`default_nettype wire

>>> rtl/core/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire spq_pkg::spq_out_t m_data
);
    import spq_pkg::*;

    // A waiting result word holds until taken.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // A call on an empty queue reports no entry and leaves the count at zero.
    a_empty_call: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.outcome == OUTC_EMPTY |->
            m_data.popped_tag == '0 && m_data.popped_level == '0 &&
            m_data.room_code == ROOM_NONE && m_data.entry_count == '0)
        else $error("empty call reported an entry");

    // A popped entry carries the room code of its level.
    a_pop_room: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.outcome == OUTC_POPPED |->
            m_data.room_code == room_for(m_data.popped_level))
        else $error("room code does not match popped level");

    // For depths up to 31, an add leaves at least one entry and the count never exceeds the depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (QUEUE_DEPTH > 31 ||
            (m_data.entry_count <= 5'(QUEUE_DEPTH) &&
             (m_data.outcome != OUTC_ADDED || m_data.entry_count != '0))))
        else $error("entry count out of range");

    // No result appears in the cycle after an input word is accepted.
    a_not_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind stable_priority_queue_top spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

>>> bench/stable_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_top_tb
// Self-checking bench for the stable priority queue. A short table of directed
// words calls the empty queue, fills it past full and drains part of it. A long
// random run follows, with phases that lean toward adds or toward calls so that
// the queue keeps swinging between empty and full. Every result word is checked
// field by field against its typed table row or an in-bench sorted queue model.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_WORDS = 950;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        spq_in_t  word;
        bit       typed;
        spq_out_t want;
    } plan_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    spq_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b1;
    spq_out_t m_data;

    spq_entry_t ward_line[$];
    spq_out_t   pending_results[$];
    plan_row_t  plan[$];

    int  mismatches   = 0;
    int  cycle_count  = 0;
    int  results_seen = 0;
    int  rx_hold      = 0;
    bit  rx_calm      = 1'b0;
    bit  tx_calm      = 1'b0;

    stable_priority_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("stable_priority_queue_top test failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // Model of the queue: entries sorted by level, a new entry goes behind
    // every entry of equal or lower level.
    function automatic spq_out_t triage_step(spq_in_t w);
        spq_out_t   r;
        spq_entry_t e;
        int         pos;
        r = '{outcome: OUTC_ADDED, popped_tag: 16'h0, popped_level: 3'h0,
              room_code: ROOM_NONE, entry_count: 5'd0};
        if (w.opcode == OP_ADD) begin
            if (ward_line.size() >= DEPTH) begin
                r.outcome = OUTC_FULL;
            end else begin
                pos = 0;
                while (pos < ward_line.size() && ward_line[pos].level <= w.priority_level) begin
                    pos++;
                end
                e.level = w.priority_level;
                e.tag   = w.patient_tag;
                ward_line.insert(pos, e);
            end
        end else if (ward_line.size() == 0) begin
            r.outcome = OUTC_EMPTY;
        end else begin
            e = ward_line.pop_front();
            r.outcome      = OUTC_POPPED;
            r.popped_tag   = e.tag;
            r.popped_level = e.level;
            case (e.level)
                LEVEL_CRITICAL: begin
                    r.room_code = ROOM_EMERGENCY;
                end
                LEVEL_SERIOUS: begin
                    r.room_code = ROOM_EXAMINATION;
                end
                LEVEL_FAIR, LEVEL_GOOD: begin
                    r.room_code = ROOM_CONSULTATION;
                end
                default: begin
                    r.room_code = ROOM_NONE;
                end
            endcase
        end
        r.entry_count = 5'(ward_line.size());
        return r;
    endfunction

    task automatic add_row(logic op, logic [2:0] lvl, logic [15:0] tag, bit typed,
                           logic [1:0] outc, logic [4:0] cnt);
        plan_row_t row;
        row.word  = '{opcode: op, priority_level: lvl, patient_tag: tag};
        row.typed = typed;
        row.want  = '{outcome: outc, popped_tag: 16'h0, popped_level: 3'h0,
                      room_code: ROOM_NONE, entry_count: cnt};
        plan.push_back(row);
    endtask

    // Drives one word after a random gap, none when calm, and records its expected
    // result once the handshake completes; valid stays high across back-to-back words.
    task automatic send_word(spq_in_t w, bit typed, spq_out_t want);
        int       gap;
        spq_out_t predicted;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = triage_step(w);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge aclk) begin
        spq_out_t want;
        int       hold;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    check_field("outcome", m_data.outcome, want.outcome);
                    check_field("popped_tag", m_data.popped_tag, want.popped_tag);
                    check_field("popped_level", m_data.popped_level, want.popped_level);
                    check_field("room_code", m_data.room_code, want.room_code);
                    check_field("entry_count", m_data.entry_count, want.entry_count);
                end
                results_seen++;
                if (results_seen % 40 == 0) begin
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                hold = rx_calm ? 0 : $urandom_range(0, 15);
                if (hold != 0) begin
                    m_ready <= 1'b0;
                end
                rx_hold = hold;
            end else if (!m_ready) begin
                rx_hold--;
                if (rx_hold <= 0) begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        spq_in_t  w;
        spq_out_t blank;
        int       add_pct;
        logic [2:0] fill_levels[16];

        fill_levels = '{3'd4, 3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5,
                        3'd6, 3'd1, 3'd2, 3'd3, 3'd0, 3'd4, 3'd7, 3'd2};
        blank   = '0;
        add_pct = 50;

        // Call on an empty queue, sixteen adds over every level with repeated
        // levels, one add into a full queue, then a partial drain.
        add_row(OP_CALL, 3'd7, 16'hFFFF, 1'b1, OUTC_EMPTY, 5'd0);
        for (int i = 0; i < DEPTH; i++) begin
            add_row(OP_ADD, fill_levels[i], (i == 0) ? 16'hFFFF : 16'(i * 16'h1111 + i),
                    1'b1, OUTC_ADDED, 5'(i + 1));
        end
        add_row(OP_ADD, 3'd0, 16'h0000, 1'b1, OUTC_FULL, 5'd16);
        for (int i = 0; i < 6; i++) begin
            add_row(OP_CALL, 3'(i), 16'(i), 1'b0, OUTC_POPPED, 5'd0);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            send_word(plan[i].word, plan[i].typed, plan[i].want);
        end

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: add_pct = 80;
                    1: add_pct = 50;
                    default: add_pct = 20;
                endcase
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            w.opcode = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_CALL;
            // Mostly the four named levels so that equal levels meet often.
            if ($urandom_range(0, 4) == 0) begin
                w.priority_level = 3'($urandom_range(0, 7));
            end else begin
                w.priority_level = 3'($urandom_range(1, 4));
            end
            case ($urandom_range(0, 15))
                0: w.patient_tag = 16'h0000;
                1: w.patient_tag = 16'hFFFF;
                default: w.patient_tag = 16'($urandom);
            endcase
            send_word(w, 1'b0, blank);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0) begin
            $display("stable_priority_queue_top test passed");
        end else begin
            $display("stable_priority_queue_top test failed");
        end
        $finish;
    end

endmodule
